[rtl/core/tmqe_pkg.sv]
// shared types and constants of the typed message queue engine
package tmqe_pkg;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_NOMSG   = 3'd3;
    localparam logic [2:0] ST_TOOBIG  = 3'd4;

    localparam logic [16:0] CAPACITY_RESET = 17'd16384;
    localparam logic [16:0] CAPACITY_LIMIT = 17'd65536;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_FINISH,
        S_SHIFT
    } t_state;

    typedef struct packed {
        logic [63:0] msg_type;
        logic [13:0] length;
        logic [15:0] handle;
    } t_entry;

    typedef struct packed {
        logic load;
        logic eval;
        logic scan_step;
        logic finish;
        logic shift_step;
    } t_cmd;

    typedef struct packed {
        logic eval_done;
        logic scan_done;
        logic need_shift;
        logic shift_done;
    } t_sts;

endpackage

[rtl/core/typed_message_queue_engine.sv]
// top level of the typed message queue engine
//
// one ordered queue of typed messages; a request is a transfer on start/busy
// carrying an opcode (send or receive), a type or selector, a length,
// a payload handle and four flags
// a request is taken at a clock edge with start high and busy low
// every request returns exactly one result, shown for one cycle with o_strobe
// a send, or a receive with bad copy flags, is decided in the eval state,
// which registers its result and returns to idle for the next transfer
// a receive that passes the flag checks scans all stored entries through the
// single read port of the entry memory and registers its result in the finish
// state, then removal shifts the entries above the picked one down, one per
// cycle, before busy drops
// capacity is written through i_cfg_we/i_cfg_wdata; the user must do so only
// while idle, which the block leaves unchecked; values above 65536 are dropped
// reset empties the queue and loads a capacity of 16384; the entry memory
// itself is not cleared
// the receiver cannot stall: a result must be taken in its strobe cycle
module typed_message_queue_engine
    import tmqe_pkg::*;
#(
    parameter int MAX_ENTRIES       = 256,
    parameter int MAX_MESSAGE_BYTES = 8192
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [16:0]        i_cfg_wdata,
    input  logic               i_opcode,
    input  logic signed [63:0] i_msg_type,
    input  logic [13:0]        i_length,
    input  logic [15:0]        i_payload_handle,
    input  logic               i_flag_nowait,
    input  logic               i_flag_noerror,
    input  logic               i_flag_except,
    input  logic               i_flag_copy,
    output logic               o_strobe,
    output logic [2:0]         o_status,
    output logic [13:0]        o_copied_length,
    output logic signed [63:0] o_type_out,
    output logic [15:0]        o_handle_out
);

    t_cmd cmd;
    t_sts sts;

    tmqe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    tmqe_dp #(
        .MAX_ENTRIES       (MAX_ENTRIES),
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_opcode         (i_opcode),
        .i_msg_type       (i_msg_type),
        .i_length         (i_length),
        .i_payload_handle (i_payload_handle),
        .i_flag_nowait    (i_flag_nowait),
        .i_flag_noerror   (i_flag_noerror),
        .i_flag_except    (i_flag_except),
        .i_flag_copy      (i_flag_copy),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_copied_length  (o_copied_length),
        .o_type_out       (o_type_out),
        .o_handle_out     (o_handle_out)
    );

endmodule

[rtl/core/tmqe_ctrl.sv]
// controller state machine of the typed message queue engine
module tmqe_ctrl
    import tmqe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = i_sts.eval_done ? S_IDLE : S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_FINISH;
            end
            S_FINISH: begin
                n_state = i_sts.need_shift ? S_SHIFT : S_IDLE;
            end
            S_SHIFT: begin
                if (i_sts.shift_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_EVAL:   o_cmd.eval       = 1'b1;
            S_SCAN:   o_cmd.scan_step  = 1'b1;
            S_FINISH: o_cmd.finish     = 1'b1;
            S_SHIFT:  o_cmd.shift_step = 1'b1;
            default:  busy             = 1'b1;
        endcase
    end

endmodule

[rtl/core/tmqe_dp.sv]
// datapath of the typed message queue engine: entry memory, counters, scan and result
module tmqe_dp
    import tmqe_pkg::*;
#(
    parameter int MAX_ENTRIES       = 256,
    parameter int MAX_MESSAGE_BYTES = 8192
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_cfg_we,
    input  logic [16:0]        i_cfg_wdata,
    input  logic               i_opcode,
    input  logic signed [63:0] i_msg_type,
    input  logic [13:0]        i_length,
    input  logic [15:0]        i_payload_handle,
    input  logic               i_flag_nowait,
    input  logic               i_flag_noerror,
    input  logic               i_flag_except,
    input  logic               i_flag_copy,
    output logic               o_strobe,
    output logic [2:0]         o_status,
    output logic [13:0]        o_copied_length,
    output logic signed [63:0] o_type_out,
    output logic [15:0]        o_handle_out
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [16:0] MAXB = 17'(MAX_MESSAGE_BYTES);
    localparam logic [31:0] MAXE = 32'(MAX_ENTRIES);

    t_entry r_mem [MAX_ENTRIES];

    logic [16:0]   r_cap;
    logic [CW-1:0] r_count;
    logic [16:0]   r_bytes;

    logic          r_op;
    logic [63:0]   r_type;
    logic [13:0]   r_len;
    logic [15:0]   r_handle;
    logic          r_nowait, r_noerr, r_except, r_copy;

    logic [CW-1:0] r_ptr;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    t_entry        r_rdata;
    logic          r_found;
    logic [IW-1:0] r_sel;
    t_entry        r_best;

    logic          mem_we, mem_re;
    logic [IW-1:0] mem_wa, mem_ra;
    t_entry        mem_wd;

    logic          send_bad, send_full, copy_bad, idx_ok, match;
    logic [63:0]   ceiling;
    logic [16:0]   len17, size17, rlen17;
    logic [2:0]    recv_st;

    always_comb begin
        len17     = {3'b000, r_len};
        send_bad  = r_noerr || r_except || r_copy || (len17 > MAXB) ||
                    (r_type == 64'd0) || r_type[63];
        send_full = (r_bytes > r_cap) || (len17 > (r_cap - r_bytes)) ||
                    (32'(r_count) >= 32'(r_cap)) || (32'(r_count) >= MAXE);
        copy_bad  = r_copy && (!r_nowait || r_except);
        idx_ok    = r_type < 64'(r_count);
        ceiling   = 64'd0 - r_type;
        if (r_copy) begin
            match = idx_ok && (r_rd_idx == r_type[IW-1:0]);
        end else if (r_type == 64'd0) begin
            match = !r_found && (r_rd_idx == '0);
        end else if (!r_type[63]) begin
            match = !r_found && (r_except ? (r_rdata.msg_type != r_type)
                                          : (r_rdata.msg_type == r_type));
        end else begin
            match = (r_rdata.msg_type <= ceiling) &&
                    (!r_found || (r_rdata.msg_type < r_best.msg_type));
        end
        size17 = (len17 > MAXB) ? MAXB : len17;
        rlen17 = {3'b000, r_best.length};
        if (!r_found) recv_st = ST_NOMSG;
        else if ((rlen17 > size17) && !r_noerr) recv_st = ST_TOOBIG;
        else if (r_copy && (rlen17 > size17)) recv_st = ST_INVALID;
        else recv_st = ST_OK;
    end

    assign o_sts.eval_done  = !r_op || copy_bad;
    assign o_sts.scan_done  = (r_ptr == r_count) && !r_rd_vld;
    assign o_sts.need_shift = (recv_st == ST_OK) && !r_copy;
    assign o_sts.shift_done = (r_ptr > r_count) && !r_rd_vld;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_count[IW-1:0];
        mem_wd = '{msg_type: r_type, length: r_len, handle: r_handle};
        mem_re = 1'b0;
        mem_ra = r_ptr[IW-1:0];
        if (i_cmd.eval && !r_op && !send_bad && !send_full) begin
            mem_we = 1'b1;
        end
        if (i_cmd.shift_step && r_rd_vld) begin
            mem_we = 1'b1;
            mem_wa = r_rd_idx - 1'b1;
            mem_wd = r_rdata;
        end
        if (i_cmd.scan_step && (r_ptr < r_count)) mem_re = 1'b1;
        if (i_cmd.shift_step && (r_ptr <= r_count)) mem_re = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (mem_re) r_rdata <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_type   <= i_msg_type;
            r_len    <= i_length;
            r_handle <= i_payload_handle;
            r_nowait <= i_flag_nowait;
            r_noerr  <= i_flag_noerror;
            r_except <= i_flag_except;
            r_copy   <= i_flag_copy;
        end
        if (mem_re) r_rd_idx <= mem_ra;
        if (i_cmd.scan_step && r_rd_vld && match) begin
            r_sel  <= r_rd_idx;
            r_best <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CAPACITY_RESET;
            r_count  <= '0;
            r_bytes  <= '0;
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= (i_cmd.eval && (!r_op || copy_bad)) || i_cmd.finish;
            r_rd_vld <= mem_re;
            if (i_cfg_we && (i_cfg_wdata <= CAPACITY_LIMIT)) r_cap <= i_cfg_wdata;
            if (i_cmd.eval) begin
                r_ptr   <= '0;
                r_found <= 1'b0;
                if (!r_op) begin
                    if (send_bad) begin
                        o_status <= ST_INVALID;
                    end else if (send_full) begin
                        o_status <= ST_FULL;
                    end else begin
                        o_status <= ST_OK;
                        r_count  <= r_count + 1'b1;
                        r_bytes  <= r_bytes + len17;
                    end
                end else if (copy_bad) begin
                    o_status <= ST_INVALID;
                end
                o_copied_length <= '0;
                o_type_out      <= '0;
                o_handle_out    <= '0;
            end
            if (mem_re) r_ptr <= r_ptr + 1'b1;
            if (i_cmd.scan_step && r_rd_vld && match) r_found <= 1'b1;
            if (i_cmd.finish) begin
                o_status <= recv_st;
                if (recv_st == ST_OK) begin
                    o_copied_length <= (size17 < rlen17) ? size17[13:0] : rlen17[13:0];
                    o_type_out      <= r_best.msg_type;
                    o_handle_out    <= r_best.handle;
                    if (!r_copy) begin
                        r_bytes <= (r_bytes >= rlen17) ? (r_bytes - rlen17) : 17'd0;
                        r_count <= r_count - 1'b1;
                        r_ptr   <= CW'(r_sel) + 1'b1;
                    end
                end
            end
        end
    end

endmodule

[rtl/core/tmqe_checker.sv]
// port-level checker of the typed message queue engine and its bind
module tmqe_checker
    import tmqe_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [2:0]  o_status,
    input logic [13:0] o_copied_length,
    input logic [63:0] o_type_out,
    input logic [15:0] o_handle_out
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_strobe)
        else $error("not idle after reset");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("transfer did not make the block busy");

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without a request in flight");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status != ST_OK) |->
            (o_copied_length == 14'd0) && (o_type_out == 64'd0) && (o_handle_out == 16'd0))
        else $error("failed result carries data");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_status <= ST_TOOBIG))
        else $error("status code out of range");

endmodule

bind typed_message_queue_engine tmqe_checker u_tmqe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_strobe        (o_strobe),
    .o_status        (o_status),
    .o_copied_length (o_copied_length),
    .o_type_out      (o_type_out),
    .o_handle_out    (o_handle_out)
);
